### sv/url_qsd_pkg.sv
// Package: codes, character constants and hex digit decode for the query string decoder.
`default_nettype none
package url_qsd_pkg;

    localparam int ByteWidth = 8;
    localparam int KindWidth = 2;

    localparam logic [KindWidth-1:0] KIND_KEY_BYTE   = 2'd0;
    localparam logic [KindWidth-1:0] KIND_VALUE_BYTE = 2'd1;
    localparam logic [KindWidth-1:0] KIND_PAIR_DONE  = 2'd2;
    localparam logic [KindWidth-1:0] KIND_KEY_DROP   = 2'd3;

    localparam logic [ByteWidth-1:0] CH_EQUALS  = 8'h3D;
    localparam logic [ByteWidth-1:0] CH_AMP     = 8'h26;
    localparam logic [ByteWidth-1:0] CH_PLUS    = 8'h2B;
    localparam logic [ByteWidth-1:0] CH_PERCENT = 8'h25;
    localparam logic [ByteWidth-1:0] CH_SPACE   = 8'h20;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2,
        ESC_RSVD = 2'd3
    } esc_phase_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] nibble;
    } hex_t;

    function automatic hex_t hex_digit(input logic [ByteWidth-1:0] c);
        hex_t r;
        r.ok     = 1'b1;
        r.nibble = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.nibble = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r.nibble = 4'(c[2:0] + 3'd1) + 4'd8;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### sv/url_query_string_decoder.sv
// Top level: streaming application/x-www-form-urlencoded key/value decoder.
//
//  channel | ports                                      | dir | meaning
//  s_      | s_valid s_ready s_char_in s_end_of_string  | in  | raw byte or end of string
//  m_      | m_valid m_ready m_char_out m_kind          | out | decoded byte or pair marker
//
// One request per cycle sustained while the result register is not stalled; a
// byte passes through the input register and then the result register. Token
// state updates when the input register hands its request on. Synchronous active
// low reset clears state and both valid flags. A stalled result register
// holds the input register, which then holds s_ready low.
`default_nettype none
module url_query_string_decoder (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_in,
    input  wire logic       s_end_of_string,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_char_out,
    output logic [1:0]      m_kind
);

    logic       in_vld_reg;
    logic [7:0] in_char_reg;
    logic       in_eos_reg;

    logic                    in_value_reg, in_value_next;
    url_qsd_pkg::esc_phase_t esc_reg, esc_next;
    logic [3:0]              high_reg, high_next;
    logic                    cut_reg, cut_next;

    logic       out_vld_reg;
    logic [7:0] out_char_reg;
    logic [1:0] out_kind_reg;

    logic       out_free;
    logic       advance;
    logic       emit;
    logic [7:0] emit_char;
    logic [1:0] emit_kind;
    logic [1:0] byte_kind;
    url_qsd_pkg::hex_t hx;

    assign out_free = !out_vld_reg || m_ready;
    assign advance  = in_vld_reg && out_free;
    assign s_ready  = !in_vld_reg || out_free;

    assign m_valid    = out_vld_reg;
    assign m_char_out = out_char_reg;
    assign m_kind     = out_kind_reg;

    always_comb begin
        in_value_next = in_value_reg;
        esc_next      = esc_reg;
        high_next     = high_reg;
        cut_next      = cut_reg;
        emit          = 1'b0;
        emit_char     = 8'd0;
        emit_kind     = url_qsd_pkg::KIND_KEY_BYTE;
        byte_kind     = in_value_reg ? url_qsd_pkg::KIND_VALUE_BYTE
                                     : url_qsd_pkg::KIND_KEY_BYTE;
        hx            = url_qsd_pkg::hex_digit(in_char_reg);

        priority if (in_eos_reg) begin
            emit          = 1'b1;
            emit_kind     = in_value_reg ? url_qsd_pkg::KIND_PAIR_DONE
                                         : url_qsd_pkg::KIND_KEY_DROP;
            in_value_next = 1'b0;
            esc_next      = url_qsd_pkg::ESC_NONE;
            high_next     = 4'd0;
            cut_next      = 1'b0;
        end else if (!in_value_reg && in_char_reg == url_qsd_pkg::CH_EQUALS) begin
            in_value_next = 1'b1;
            esc_next      = url_qsd_pkg::ESC_NONE;
            high_next     = 4'd0;
            cut_next      = 1'b0;
        end else if (in_value_reg && in_char_reg == url_qsd_pkg::CH_AMP) begin
            emit          = 1'b1;
            emit_kind     = url_qsd_pkg::KIND_PAIR_DONE;
            in_value_next = 1'b0;
            esc_next      = url_qsd_pkg::ESC_NONE;
            high_next     = 4'd0;
            cut_next      = 1'b0;
        end else if (cut_reg) begin
            // rest of token suppressed
        end else begin
            unique case (esc_reg)
                url_qsd_pkg::ESC_HIGH: begin
                    if (hx.ok) begin
                        high_next = hx.nibble;
                        esc_next  = url_qsd_pkg::ESC_LOW;
                    end else begin
                        esc_next = url_qsd_pkg::ESC_NONE;
                        cut_next = 1'b1;
                    end
                end
                url_qsd_pkg::ESC_LOW: begin
                    esc_next = url_qsd_pkg::ESC_NONE;
                    if (hx.ok) begin
                        emit      = 1'b1;
                        emit_char = {high_reg, hx.nibble};
                        emit_kind = byte_kind;
                    end else begin
                        cut_next = 1'b1;
                    end
                end
                default: begin
                    emit_kind = byte_kind;
                    if (in_char_reg == url_qsd_pkg::CH_PLUS) begin
                        emit      = 1'b1;
                        emit_char = url_qsd_pkg::CH_SPACE;
                    end else if (in_char_reg == url_qsd_pkg::CH_PERCENT) begin
                        esc_next = url_qsd_pkg::ESC_HIGH;
                    end else begin
                        emit      = 1'b1;
                        emit_char = in_char_reg;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            in_value_reg <= 1'b0;
            esc_reg      <= url_qsd_pkg::ESC_NONE;
            high_reg     <= 4'd0;
            cut_reg      <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (out_free) begin
                out_vld_reg <= advance && emit;
            end
            if (advance) begin
                in_value_reg <= in_value_next;
                esc_reg      <= esc_next;
                high_reg     <= high_next;
                cut_reg      <= cut_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_in;
            in_eos_reg  <= s_end_of_string;
        end
        if (advance && emit) begin
            out_char_reg <= emit_char;
            out_kind_reg <= emit_kind;
        end
    end

endmodule
`default_nettype wire
